### rtl/core/mse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_pkg
// Shared types and constants of the merge sort engine: item structs for the
// input and result channels and the sequencer state encoding.
// ----------------------------------------------------------------------------
package mse_pkg;

  localparam int DATA_W = 32;

  // one input transfer
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } in_item_t;

  // one result transfer
  typedef struct packed {
    logic signed [DATA_W-1:0] value_res;
    logic                     last_res;
    logic                     overflow;
  } out_item_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_MERGE,
    ST_EMIT
  } mse_state_t;

endpackage

### rtl/core/merge_sort_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// merge_sort_engine
// Collects a set of signed values and emits them in ascending order after a
// bottom-up merge sort between two run stores.
// ----------------------------------------------------------------------------
// Usage: values are taken one per cycle while busy is low (start high); up
// to MAX_ITEMS are kept, further ones are dropped and flag overflow on every
// result of that set. The transfer with last set ends the set and raises
// busy. For N kept values the engine runs ceil(log2 N) merge passes (one merged
// word per cycle, limited by the single write port of the destination store),
// then emits the N results, one per cycle, each marked by out_valid for exactly
// one cycle; the receiver cannot stall them. Busy falls in the cycle after the
// last result.
// ----------------------------------------------------------------------------
module merge_sort_engine #(
  parameter int MAX_ITEMS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  mse_pkg::in_item_t  in_data,
  output logic               out_valid,
  output mse_pkg::out_item_t out_data
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int PW = $clog2(MAX_ITEMS) + 2;

  mse_pkg::mse_state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          dropped_r, dropped_nxt;
  logic          src_b_r, src_b_nxt;
  logic [PW-1:0] width_r, width_nxt;
  logic [PW-1:0] p_r, p_nxt;
  logic [PW-1:0] q_r, q_nxt;
  logic [PW-1:0] mid_r, mid_nxt;
  logic [PW-1:0] hi_r, hi_nxt;
  logic [PW-1:0] w_r, w_nxt;

  logic          in_xfer;
  logic          full;
  logic [PW-1:0] n_w;
  logic [PW-1:0] p_inc, q_inc, w_inc;
  logic [PW-1:0] seg_mid, seg_hi, init_mid, init_hi;
  logic          p_live, q_live, take_p;

  logic signed [mse_pkg::DATA_W-1:0] a_rd_p, a_rd_q, b_rd_p, b_rd_q;
  logic signed [mse_pkg::DATA_W-1:0] src_p, src_q, merge_word;

  logic                              a_we;
  logic [AW-1:0]                     a_waddr;
  logic signed [mse_pkg::DATA_W-1:0] a_wdata;
  logic                              b_we;

  // run stores
  mse_ram #(.DEPTH(MAX_ITEMS)) u_store_a (
    .clk     (clk),
    .we      (a_we),
    .waddr   (a_waddr),
    .wdata   (a_wdata),
    .raddr_a (p_nxt[AW-1:0]),
    .raddr_b (q_nxt[AW-1:0]),
    .rdata_a (a_rd_p),
    .rdata_b (a_rd_q)
  );

  mse_ram #(.DEPTH(MAX_ITEMS)) u_store_b (
    .clk     (clk),
    .we      (b_we),
    .waddr   (w_r[AW-1:0]),
    .wdata   (merge_word),
    .raddr_a (p_nxt[AW-1:0]),
    .raddr_b (q_nxt[AW-1:0]),
    .rdata_a (b_rd_p),
    .rdata_b (b_rd_q)
  );

  // handshake and occupancy
  assign busy    = (state_r != mse_pkg::ST_IDLE);
  assign in_xfer = start && !busy;
  assign full    = (count_r == CW'(MAX_ITEMS));
  assign n_w     = PW'(count_r);

  // pick the source store of the current pass
  assign src_p = src_b_r ? b_rd_p : a_rd_p;
  assign src_q = src_b_r ? b_rd_q : a_rd_q;

  // merge decision: left head wins when strictly smaller or once the right run is spent; ties go right
  assign p_live     = (p_r < mid_r);
  assign q_live     = (q_r < hi_r);
  assign take_p     = p_live && (!q_live || (src_p < src_q));
  assign merge_word = take_p ? src_p : src_q;

  assign p_inc = p_r + PW'(1);
  assign q_inc = q_r + PW'(1);
  assign w_inc = w_r + PW'(1);

  // bounds of the next segment and of the first segment of a pass
  assign seg_mid  = ((hi_r + width_r) < n_w) ? (hi_r + width_r) : n_w;
  assign seg_hi   = ((hi_r + (width_r << 1)) < n_w) ? (hi_r + (width_r << 1)) : n_w;
  assign init_mid = (width_r < n_w) ? width_r : n_w;
  assign init_hi  = ((width_r << 1) < n_w) ? (width_r << 1) : n_w;

  // store write ports: load into A, merge into the destination store
  assign a_we    = (in_xfer && !full) || ((state_r == mse_pkg::ST_MERGE) && src_b_r);
  assign a_waddr = (state_r == mse_pkg::ST_MERGE) ? w_r[AW-1:0] : count_r[AW-1:0];
  assign a_wdata = (state_r == mse_pkg::ST_MERGE) ? merge_word : in_data.value;
  assign b_we    = (state_r == mse_pkg::ST_MERGE) && !src_b_r;

  // result channel
  assign out_valid          = (state_r == mse_pkg::ST_EMIT);
  assign out_data.value_res = src_p;
  assign out_data.last_res  = (p_inc == n_w);
  assign out_data.overflow  = dropped_r;

  // hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= mse_pkg::ST_IDLE;
      count_r   <= '0;
      dropped_r <= 1'b0;
      src_b_r   <= 1'b0;
      width_r   <= '0;
      p_r       <= '0;
      q_r       <= '0;
      mid_r     <= '0;
      hi_r      <= '0;
      w_r       <= '0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      dropped_r <= dropped_nxt;
      src_b_r   <= src_b_nxt;
      width_r   <= width_nxt;
      p_r       <= p_nxt;
      q_r       <= q_nxt;
      mid_r     <= mid_nxt;
      hi_r      <= hi_nxt;
      w_r       <= w_nxt;
    end
  end

  // sequence load, merge passes and emission
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    dropped_nxt = dropped_r;
    src_b_nxt   = src_b_r;
    width_nxt   = width_r;
    p_nxt       = p_r;
    q_nxt       = q_r;
    mid_nxt     = mid_r;
    hi_nxt      = hi_r;
    w_nxt       = w_r;
    unique case (state_r)
      mse_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (full) begin
            dropped_nxt = 1'b1;
          end else begin
            count_nxt = count_r + CW'(1);
          end
          if (in_data.last) begin
            width_nxt = PW'(1);
            src_b_nxt = 1'b0;
            state_nxt = mse_pkg::ST_START;
          end
        end
      end
      mse_pkg::ST_START: begin
        // open a pass, or go emit once one run covers the set
        p_nxt = '0;
        w_nxt = '0;
        if (width_r >= n_w) begin
          state_nxt = mse_pkg::ST_EMIT;
        end else begin
          mid_nxt   = init_mid;
          q_nxt     = init_mid;
          hi_nxt    = init_hi;
          state_nxt = mse_pkg::ST_MERGE;
        end
      end
      mse_pkg::ST_MERGE: begin
        w_nxt = w_inc;
        if (w_inc == n_w) begin
          // pass done: swap stores, double the run length
          width_nxt = width_r << 1;
          src_b_nxt = !src_b_r;
          state_nxt = mse_pkg::ST_START;
        end else if (w_inc == hi_r) begin
          // advance to the next pair of runs
          p_nxt   = hi_r;
          mid_nxt = seg_mid;
          q_nxt   = seg_mid;
          hi_nxt  = seg_hi;
        end else if (take_p) begin
          p_nxt = p_inc;
        end else begin
          q_nxt = q_inc;
        end
      end
      mse_pkg::ST_EMIT: begin
        if (p_inc == n_w) begin
          count_nxt   = '0;
          dropped_nxt = 1'b0;
          state_nxt   = mse_pkg::ST_IDLE;
        end else begin
          p_nxt = p_inc;
        end
      end
      default: begin
        state_nxt = mse_pkg::ST_IDLE;
      end
    endcase
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ITEMS))
    else $error("item count exceeds capacity");

  a_merge_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mse_pkg::ST_MERGE) |-> (w_r < n_w) && (p_r <= mid_r) && (q_r <= hi_r))
    else $error("merge pointer out of range");

  a_final_releases: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last_res) |=> !busy)
    else $error("engine still busy after final result");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (count_r != '0))
    else $error("result emitted from an empty set");

endmodule

### rtl/core/mse_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_ram
// Run store: one write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module mse_ram #(
  parameter int DEPTH = 64
) (
  input  logic                               clk,
  input  logic                               we,
  input  logic [$clog2(DEPTH)-1:0]           waddr,
  input  logic signed [mse_pkg::DATA_W-1:0]  wdata,
  input  logic [$clog2(DEPTH)-1:0]           raddr_a,
  input  logic [$clog2(DEPTH)-1:0]           raddr_b,
  output logic signed [mse_pkg::DATA_W-1:0]  rdata_a,
  output logic signed [mse_pkg::DATA_W-1:0]  rdata_b
);

  logic signed [mse_pkg::DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read ports
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
